// ===== rtl/core/cnm_pkg.sv =====
package cnm_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int MAX_DIM     = 128;
  localparam int SAMPLE_BITS = 16;

  localparam int ENT_W   = $clog2(MAX_ENTRIES);
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int GAL_AW  = ENT_W + DIM_W;
  localparam int GAL_D   = MAX_ENTRIES * MAX_DIM;
  localparam int PROD_W  = 2 * SAMPLE_BITS;
  localparam int ACC_W   = PROD_W + DIM_W;
  localparam int MB_W    = ACC_W;
  localparam int MA_W    = 2 * ACC_W;
  localparam int MP_W    = 3 * ACC_W;
  localparam int MC_W    = $clog2(MB_W);
  localparam int CNT_E_W = ENT_W + 1;
  localparam int CNT_K_W = DIM_W + 1;

  localparam int CFG_W  = 8;
  localparam int CIDX_W = 2;
  localparam int PCT_W  = 7;

  localparam logic [CIDX_W-1:0] REG_ENTRIES = 2'd0;
  localparam logic [CIDX_W-1:0] REG_LENGTH  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_THRESH  = 2'd2;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [MB_W-1:0]  PCT_SQ   = MB_W'(10000);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                          operation;
    logic [ENT_W-1:0]              entry_index;
    logic [DIM_W-1:0]              element_index;
    logic signed [SAMPLE_BITS-1:0] element_value;
    logic                          last_element;
  } in_word_t;

  typedef struct packed {
    logic             match_found;
    logic [ENT_W-1:0] match_index;
    logic [PCT_W-1:0] similarity_percent;
  } out_word_t;

  typedef struct packed {
    logic [6:0] entries_in_use;
    logic [7:0] vector_length;
    logic [6:0] threshold_percent;
  } cfg_t;

  typedef enum logic [2:0] {
    MS_D2, MS_L, MS_R, MS_QG, MS_DD, MS_TQ, MS_PQ
  } mul_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ENTRY, ST_CLEAR, ST_MAC, ST_DRAIN, ST_CHECK,
    ST_MUL_D2, ST_MUL_L, ST_MUL_R, ST_TAKE, ST_NEXT,
    ST_MUL_QG, ST_MUL_DD, ST_MUL_TQ, ST_MUL_PQ, ST_OUT
  } state_t;

  typedef struct packed {
    logic     init;
    logic     clear;
    logic     issue;
    logic     e_inc;
    logic     take;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     p_dec;
    logic     set_found;
  } cmd_t;

  typedef struct packed {
    logic k_done;
    logic e_done;
    logic pipe_busy;
    logic ent_ok;
    logic have;
    logic mul_run;
    logic mul_done;
    logic gt;
    logic thr_ok;
    logic p_more;
  } sts_t;

endpackage

// ===== rtl/core/cnm_ram.sv =====
module cnm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/cnm_mul.sv =====
module cnm_mul import cnm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  logic [MA_W-1:0] a,
  input  logic [MB_W-1:0] b,
  output logic [MP_W-1:0] prod,
  output logic            run,
  output logic            done
);

  logic [MP_W-1:0] a_r;
  logic [MB_W-1:0] b_r;
  logic [MP_W-1:0] acc_r;
  logic [MC_W-1:0] cnt_r;
  logic            run_r;
  logic            done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go && !run_r) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == MC_W'(MB_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && !run_r) begin
      a_r   <= MP_W'(a);
      b_r   <= b;
      acc_r <= '0;
      cnt_r <= '0;
    end else if (run_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r   <= a_r << 1;
      b_r   <= b_r >> 1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign prod = acc_r;
  assign run  = run_r;
  assign done = done_r;

endmodule

// ===== rtl/core/cnm_ctrl.sv =====
module cnm_ctrl import cnm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic req,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic out_valid
);

  state_t state_r;
  state_t state_nxt;
  logic   in_mul;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (req) state_nxt = ST_ENTRY;
      ST_ENTRY: begin
        if (!sts.e_done) state_nxt = ST_CLEAR;
        else if (sts.have) state_nxt = ST_MUL_QG;
        else state_nxt = ST_OUT;
      end
      ST_CLEAR:  state_nxt = ST_MAC;
      ST_MAC:    if (sts.k_done) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (!sts.pipe_busy) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = sts.ent_ok ? ST_MUL_D2 : ST_NEXT;
      ST_MUL_D2: if (sts.mul_done) state_nxt = sts.have ? ST_MUL_L : ST_TAKE;
      ST_MUL_L:  if (sts.mul_done) state_nxt = ST_MUL_R;
      ST_MUL_R:  if (sts.mul_done) state_nxt = sts.gt ? ST_TAKE : ST_NEXT;
      ST_TAKE:   state_nxt = ST_NEXT;
      ST_NEXT:   state_nxt = ST_ENTRY;
      ST_MUL_QG: if (sts.mul_done) state_nxt = ST_MUL_DD;
      ST_MUL_DD: if (sts.mul_done) state_nxt = ST_MUL_TQ;
      ST_MUL_TQ: if (sts.mul_done) state_nxt = sts.thr_ok ? ST_MUL_PQ : ST_OUT;
      ST_MUL_PQ: if (sts.mul_done && !sts.p_more) state_nxt = ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.mul_sel = MS_D2;
    in_mul    = 1'b0;
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    unique case (state_r)
      ST_IDLE:   cmd.init = req;
      ST_CLEAR:  cmd.clear = 1'b1;
      ST_MAC:    cmd.issue = !sts.k_done;
      ST_TAKE:   cmd.take = 1'b1;
      ST_NEXT:   cmd.e_inc = 1'b1;
      ST_MUL_D2: begin
        in_mul = 1'b1;
        cmd.mul_sel = MS_D2;
      end
      ST_MUL_L: begin
        in_mul = 1'b1;
        cmd.mul_sel = MS_L;
      end
      ST_MUL_R: begin
        in_mul = 1'b1;
        cmd.mul_sel = MS_R;
      end
      ST_MUL_QG: begin
        in_mul = 1'b1;
        cmd.mul_sel = MS_QG;
      end
      ST_MUL_DD: begin
        in_mul = 1'b1;
        cmd.mul_sel = MS_DD;
      end
      ST_MUL_TQ: begin
        in_mul = 1'b1;
        cmd.mul_sel = MS_TQ;
      end
      ST_MUL_PQ: begin
        in_mul = 1'b1;
        cmd.mul_sel = MS_PQ;
        cmd.p_dec = sts.mul_done && sts.p_more;
        cmd.set_found = sts.mul_done && !sts.p_more;
      end
      default: begin
        in_mul = 1'b0;
      end
    endcase
    cmd.mul_go = in_mul && !sts.mul_run && !sts.mul_done;
  end

  a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> (state_r == ST_IDLE))
    else $error("result strobe not followed by idle");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !sts.k_done)
    else $error("element read issued past vector length");

  a_mul_launch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_go |-> (!sts.mul_run && !sts.mul_done))
    else $error("multiplier launched while occupied");

  a_found_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_found |=> (state_r == ST_OUT))
    else $error("match flagged without result strobe");

endmodule

// ===== rtl/core/cnm_datapath.sv =====
module cnm_datapath import cnm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_word_t  in_word,
  input  cfg_t      cfg,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_word_t out_word
);

  logic [CNT_K_W-1:0] n_len;
  logic [CNT_E_W-1:0] m_ent;
  logic [CNT_K_W-1:0] k_r;
  logic [CNT_E_W-1:0] e_r;

  logic [SAMPLE_BITS-1:0] q_rdata;
  logic [SAMPLE_BITS-1:0] g_rdata;
  logic signed [SAMPLE_BITS-1:0] qd;
  logic signed [SAMPLE_BITS-1:0] gd;

  logic v1_r;
  logic pv_r;
  logic signed [PROD_W-1:0] pqs_r;
  logic [PROD_W-1:0] pss_r;
  logic [PROD_W-1:0] pqq_r;
  logic signed [PROD_W-1:0] m_qs;
  logic signed [PROD_W-1:0] m_ss;
  logic signed [PROD_W-1:0] m_qq;

  logic signed [ACC_W-1:0] d_r;
  logic [ACC_W-1:0] gg_r;
  logic [ACC_W-1:0] qq_r;

  logic [MA_W-1:0] d2_r;
  logic [MP_W-1:0] lhs_r;
  logic [MA_W-1:0] qg_r;
  logic [MP_W-1:0] dd_r;
  logic [MA_W-1:0] best_d2_r;
  logic [ACC_W-1:0] best_g_r;
  logic [ENT_W-1:0] best_e_r;
  logic have_r;
  logic found_r;
  logic [PCT_W-1:0] p_r;

  logic [13:0] t_sq;
  logic [13:0] p_sq;
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [MP_W-1:0] mul_p;
  logic mul_run;
  logic mul_done;

  assign n_len = (cfg.vector_length > 8'(MAX_DIM)) ? CNT_K_W'(MAX_DIM)
                                                   : CNT_K_W'(cfg.vector_length);
  assign m_ent = (cfg.entries_in_use > 7'(MAX_ENTRIES)) ? CNT_E_W'(MAX_ENTRIES)
                                                        : CNT_E_W'(cfg.entries_in_use);

  cnm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_DIM)) u_query (
    .clk   (clk),
    .we    (accept && in_word.operation == OP_QUERY),
    .waddr (in_word.element_index),
    .wdata (in_word.element_value),
    .raddr (k_r[DIM_W-1:0]),
    .rdata (q_rdata)
  );

  cnm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(GAL_D)) u_gallery (
    .clk   (clk),
    .we    (accept && in_word.operation == OP_LOAD),
    .waddr ({in_word.entry_index, in_word.element_index}),
    .wdata (in_word.element_value),
    .raddr ({e_r[ENT_W-1:0], k_r[DIM_W-1:0]}),
    .rdata (g_rdata)
  );

  assign qd   = q_rdata;
  assign gd   = g_rdata;
  assign m_qs = qd * gd;
  assign m_ss = gd * gd;
  assign m_qq = qd * qd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      pv_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    pqs_r <= m_qs;
    pss_r <= m_ss;
    pqq_r <= m_qq;
    if (cmd.clear) begin
      k_r  <= '0;
      d_r  <= '0;
      gg_r <= '0;
      qq_r <= '0;
    end else begin
      if (cmd.issue) begin
        k_r <= k_r + 1'b1;
      end
      if (pv_r) begin
        d_r  <= d_r + ACC_W'(pqs_r);
        gg_r <= gg_r + ACC_W'(pss_r);
        qq_r <= qq_r + ACC_W'(pqq_r);
      end
    end
  end

  assign t_sq = 14'(cfg.threshold_percent) * 14'(cfg.threshold_percent);
  assign p_sq = 14'(p_r) * 14'(p_r);

  always_comb begin
    unique case (cmd.mul_sel)
      MS_D2: begin
        mul_a = MA_W'(unsigned'(d_r));
        mul_b = unsigned'(d_r);
      end
      MS_L: begin
        mul_a = d2_r;
        mul_b = best_g_r;
      end
      MS_R: begin
        mul_a = best_d2_r;
        mul_b = gg_r;
      end
      MS_QG: begin
        mul_a = MA_W'(qq_r);
        mul_b = best_g_r;
      end
      MS_DD: begin
        mul_a = best_d2_r;
        mul_b = PCT_SQ;
      end
      MS_TQ: begin
        mul_a = qg_r;
        mul_b = MB_W'(t_sq);
      end
      MS_PQ: begin
        mul_a = qg_r;
        mul_b = MB_W'(p_sq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cnm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_p),
    .run   (mul_run),
    .done  (mul_done)
  );

  always_ff @(posedge clk) begin
    if (mul_done) begin
      unique case (cmd.mul_sel)
        MS_D2:   d2_r  <= mul_p[MA_W-1:0];
        MS_L:    lhs_r <= mul_p;
        MS_QG:   qg_r  <= mul_p[MA_W-1:0];
        MS_DD:   dd_r  <= mul_p;
        default: lhs_r <= lhs_r;
      endcase
    end
    if (cmd.take) begin
      best_e_r  <= e_r[ENT_W-1:0];
      best_d2_r <= d2_r;
      best_g_r  <= gg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r  <= 1'b0;
      found_r <= 1'b0;
      e_r     <= '0;
      p_r     <= PCT_FULL;
    end else begin
      if (cmd.init) begin
        have_r  <= 1'b0;
        found_r <= 1'b0;
        e_r     <= '0;
        p_r     <= PCT_FULL;
      end else begin
        if (cmd.take) have_r <= 1'b1;
        if (cmd.e_inc) e_r <= e_r + 1'b1;
        if (cmd.p_dec) p_r <= p_r - 1'b1;
        if (cmd.set_found) found_r <= 1'b1;
      end
    end
  end

  always_comb begin
    sts.k_done    = (k_r == n_len);
    sts.e_done    = (e_r == m_ent);
    sts.pipe_busy = v1_r || pv_r;
    sts.ent_ok    = (qq_r != '0) && (gg_r != '0) && !d_r[ACC_W-1] && (d_r != '0);
    sts.have      = have_r;
    sts.mul_run   = mul_run;
    sts.mul_done  = mul_done;
    sts.gt        = (lhs_r > mul_p);
    sts.thr_ok    = (dd_r > mul_p);
    sts.p_more    = (p_r != '0) && (mul_p > dd_r);
  end

  always_comb begin
    out_word = '0;
    if (found_r) begin
      out_word.match_found        = 1'b1;
      out_word.match_index        = best_e_r;
      out_word.similarity_percent = p_r;
    end
  end

endmodule

// ===== rtl/core/cosine_nearest_match.sv =====
// Channel   Ports                         Transfer
// input     start, busy, in_word          start high while busy is low
// result    out_valid, out_word           one-cycle strobe, always taken
// config    cfg_we, cfg_index, cfg_data   cfg_we high, no wait
//
// A load word or a non-final query word is written to its store; busy stays low.
// A final query word starts a search over m entries of n elements and, when the
// threshold is met, a percent search, both paced by the single-port gallery read
// and the shared bit-serial 39-bit multiplier.
// Reset is synchronous and active low; the stores are not cleared.
// The result strobe lasts one cycle and the receiver cannot stall it.
module cosine_nearest_match import cnm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_word_t          in_word,
  output logic              out_valid,
  output out_word_t         out_word,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic accept;
  logic req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entries_in_use    <= 7'd0;
      cfg_r.vector_length     <= 8'd128;
      cfg_r.threshold_percent <= 7'd70;
    end else if (cfg_we) begin
      priority case (cfg_index)
        REG_ENTRIES: cfg_r.entries_in_use    <= cfg_data[6:0];
        REG_LENGTH:  cfg_r.vector_length     <= cfg_data;
        REG_THRESH:  cfg_r.threshold_percent <= cfg_data[6:0];
        default:     cfg_r <= cfg_r;
      endcase
    end
  end

  assign accept = start && !busy;
  assign req    = accept && in_word.operation == OP_QUERY && in_word.last_element;

  cnm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  cnm_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_word  (in_word),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule
